// File: hw/rtl/mi4_pkg.sv
// shared constants and the cofactor index table for the 4x4 matrix inverse
package mi4_pkg;

    // default element format, signed Q16.16
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // width of the threshold register
    localparam int DET_MIN_W = 63;

    // digit width of the shared digit-serial multiplier
    localparam int DIGIT_W = 8;

    // each inverse entry j: six triples of storage positions, first three
    // terms added, last three subtracted
    localparam logic [3:0] COF_TAB [16][6][3] = '{
        '{'{4'd5, 4'd10, 4'd15}, '{4'd6, 4'd11, 4'd13}, '{4'd7, 4'd9, 4'd14},
          '{4'd5, 4'd11, 4'd14}, '{4'd6, 4'd9, 4'd15}, '{4'd7, 4'd10, 4'd13}},
        '{'{4'd1, 4'd11, 4'd14}, '{4'd2, 4'd9, 4'd15}, '{4'd3, 4'd10, 4'd13},
          '{4'd1, 4'd10, 4'd15}, '{4'd2, 4'd11, 4'd13}, '{4'd3, 4'd9, 4'd14}},
        '{'{4'd1, 4'd6, 4'd15}, '{4'd2, 4'd7, 4'd13}, '{4'd3, 4'd5, 4'd14},
          '{4'd1, 4'd7, 4'd14}, '{4'd2, 4'd5, 4'd15}, '{4'd3, 4'd6, 4'd13}},
        '{'{4'd1, 4'd7, 4'd10}, '{4'd2, 4'd5, 4'd11}, '{4'd3, 4'd6, 4'd9},
          '{4'd1, 4'd6, 4'd11}, '{4'd2, 4'd7, 4'd9}, '{4'd3, 4'd5, 4'd10}},
        '{'{4'd4, 4'd11, 4'd14}, '{4'd6, 4'd8, 4'd15}, '{4'd7, 4'd10, 4'd12},
          '{4'd4, 4'd10, 4'd15}, '{4'd6, 4'd11, 4'd12}, '{4'd7, 4'd8, 4'd14}},
        '{'{4'd0, 4'd10, 4'd15}, '{4'd2, 4'd11, 4'd12}, '{4'd3, 4'd8, 4'd14},
          '{4'd0, 4'd11, 4'd14}, '{4'd2, 4'd8, 4'd15}, '{4'd3, 4'd10, 4'd12}},
        '{'{4'd0, 4'd7, 4'd14}, '{4'd2, 4'd4, 4'd15}, '{4'd3, 4'd6, 4'd12},
          '{4'd0, 4'd6, 4'd15}, '{4'd2, 4'd7, 4'd12}, '{4'd3, 4'd4, 4'd14}},
        '{'{4'd0, 4'd6, 4'd11}, '{4'd2, 4'd7, 4'd8}, '{4'd3, 4'd4, 4'd10},
          '{4'd0, 4'd7, 4'd10}, '{4'd2, 4'd4, 4'd11}, '{4'd3, 4'd6, 4'd8}},
        '{'{4'd4, 4'd9, 4'd15}, '{4'd5, 4'd11, 4'd12}, '{4'd7, 4'd8, 4'd13},
          '{4'd4, 4'd11, 4'd13}, '{4'd5, 4'd8, 4'd15}, '{4'd7, 4'd9, 4'd12}},
        '{'{4'd0, 4'd11, 4'd13}, '{4'd1, 4'd8, 4'd15}, '{4'd3, 4'd9, 4'd12},
          '{4'd0, 4'd9, 4'd15}, '{4'd1, 4'd11, 4'd12}, '{4'd3, 4'd8, 4'd13}},
        '{'{4'd0, 4'd5, 4'd15}, '{4'd1, 4'd7, 4'd12}, '{4'd3, 4'd4, 4'd13},
          '{4'd0, 4'd7, 4'd13}, '{4'd1, 4'd4, 4'd15}, '{4'd3, 4'd5, 4'd12}},
        '{'{4'd0, 4'd7, 4'd9}, '{4'd1, 4'd4, 4'd11}, '{4'd3, 4'd5, 4'd8},
          '{4'd0, 4'd5, 4'd11}, '{4'd1, 4'd7, 4'd8}, '{4'd3, 4'd4, 4'd9}},
        '{'{4'd4, 4'd10, 4'd13}, '{4'd5, 4'd8, 4'd14}, '{4'd6, 4'd9, 4'd12},
          '{4'd4, 4'd9, 4'd14}, '{4'd5, 4'd10, 4'd12}, '{4'd6, 4'd8, 4'd13}},
        '{'{4'd0, 4'd9, 4'd14}, '{4'd1, 4'd10, 4'd12}, '{4'd2, 4'd8, 4'd13},
          '{4'd0, 4'd10, 4'd13}, '{4'd1, 4'd8, 4'd14}, '{4'd2, 4'd9, 4'd12}},
        '{'{4'd0, 4'd6, 4'd13}, '{4'd1, 4'd4, 4'd14}, '{4'd2, 4'd5, 4'd12},
          '{4'd0, 4'd5, 4'd14}, '{4'd1, 4'd6, 4'd12}, '{4'd2, 4'd4, 4'd13}},
        '{'{4'd0, 4'd5, 4'd10}, '{4'd1, 4'd6, 4'd8}, '{4'd2, 4'd4, 4'd9},
          '{4'd0, 4'd6, 4'd9}, '{4'd1, 4'd4, 4'd10}, '{4'd2, 4'd5, 4'd8}}
    };

endpackage

// File: hw/rtl/mi4_ram.sv
// generic single write port, single read port ram with registered read
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/mi4_mul.sv
// digit-serial unsigned multiplier, one digit of b per cycle
module mi4_mul #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
    parameter int PW         = 4 * mi4_pkg::ELEM_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PW-1:0]         a,
    input  logic [ELEM_WIDTH-1:0] b,
    output logic                  done,
    output logic [PW-1:0]         prod
);

    localparam int D    = mi4_pkg::DIGIT_W;
    localparam int NDIG = (ELEM_WIDTH + D - 1) / D;
    localparam int BW   = NDIG * D;
    localparam int CW   = $clog2(NDIG);

    logic [PW-1:0]   a_reg,    a_next;
    logic [BW-1:0]   b_reg,    b_next;
    logic [PW-1:0]   acc_reg,  acc_next;
    logic [CW-1:0]   cnt_reg,  cnt_next;
    logic            run_reg,  run_next;
    logic            done_reg, done_next;
    logic [PW+D-1:0] pp;

    // partial product of the shifted multiplicand and the low digit
    assign pp = a_reg * b_reg[D-1:0];

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = a;
            b_next   = BW'(b);
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + pp[PW-1:0];
            a_next   = a_reg << D;
            b_next   = b_reg >> D;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NDIG - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hw/rtl/mi4_div.sv
// restoring divider, one quotient bit per cycle, flags quotients too wide
module mi4_div #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
    parameter int NW         = 5 * mi4_pkg::ELEM_WIDTH_DEF,
    parameter int DNW        = 4 * mi4_pkg::ELEM_WIDTH_DEF + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NW-1:0]         num,
    input  logic [DNW-1:0]        den,
    output logic                  done,
    output logic                  big,
    output logic [ELEM_WIDTH-1:0] quo
);

    localparam int EW = ELEM_WIDTH;
    localparam int HW = NW - EW;
    localparam int XW = (HW > DNW + 1) ? HW : DNW + 1;
    localparam int CW = $clog2(EW);

    logic [DNW:0]  rem_reg,  rem_next;
    logic [EW-1:0] low_reg,  low_next;
    logic [EW-1:0] q_reg,    q_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          run_reg,  run_next;
    logic          done_reg, done_next;
    logic          big_reg,  big_next;
    logic [XW-1:0] hi_x;
    logic [XW-1:0] den_x;
    logic [DNW:0]  trial;
    logic [DNW:0]  den_e;

    assign hi_x  = XW'(num[NW-1:EW]);
    assign den_x = XW'(den);
    assign den_e = {1'b0, den};
    assign trial = {rem_reg[DNW-1:0], low_reg[EW-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        big_next  = big_reg;
        done_next = 1'b0;
        if (start)
        begin
            // high part not below divisor means quotient needs more than EW bits
            big_next = (hi_x >= den_x);
            rem_next = hi_x[DNW:0];
            low_next = num[EW-1:0];
            q_next   = '0;
            cnt_next = '0;
            if (hi_x >= den_x)
            begin
                done_next = 1'b1;
            end
            else
            begin
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= den_e)
            begin
                rem_next = trial - den_e;
                q_next   = {q_reg[EW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[EW-2:0], 1'b0};
            end
            low_next = low_reg << 1;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(EW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        big_reg <= big_next;
    end

    assign done = done_reg;
    assign big  = big_reg;
    assign quo  = q_reg;

endmodule

// File: hw/rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse top: loading, cofactor/determinant sequencer, results
// loading writes one element per start while idle; after the sixteenth, busy stays high
// through 196 multiplies and the singularity check, then per entry a cofactor read and divide
// (the divide ends early when the quotient is too wide; no divide when singular)
// 16 results follow one per entry, each strobed for one cycle with no stall possible
// reset clears the sequencer, load count and threshold (to 1); the element store is not cleared
module matrix_inverse_4x4 #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ELEM_WIDTH-1:0]          element_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mi4_pkg::DET_MIN_W-1:0]  cfg_data,
    output logic                           result_valid,
    output logic [ELEM_WIDTH-1:0]          inv_value,
    output logic [3:0]                     elem_index,
    output logic                           singular,
    output logic                           overflow,
    output logic                           last
);

    localparam int EW   = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 4 * EW;
    localparam int MW   = 3 * EW;
    localparam int CFW  = 3 * EW + 1;
    localparam int DW   = 4 * EW + 2;
    localparam int NW   = 3 * EW + 2 * F;
    localparam int THRW = mi4_pkg::DET_MIN_W + 4 * F - 32;
    localparam int CMPW = (THRW > DW) ? THRW : DW;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RA   = 13'b0000000000010,
        S_RB   = 13'b0000000000100,
        S_MUL  = 13'b0000000001000,
        S_ACC  = 13'b0000000010000,
        S_CWR  = 13'b0000000100000,
        S_DA   = 13'b0000001000000,
        S_DB   = 13'b0000010000000,
        S_DMUL = 13'b0000100000000,
        S_CHK  = 13'b0001000000000,
        S_ORA  = 13'b0010000000000,
        S_ORB  = 13'b0100000000000,
        S_DIV  = 13'b1000000000000
    } state_t;

    state_t                        state_reg,   state_next;
    logic [3:0]                    load_reg,    load_next;
    logic [3:0]                    j_reg,       j_next;
    logic [2:0]                    i_reg,       i_next;
    logic [1:0]                    k_reg,       k_next;
    logic [1:0]                    r_reg,       r_next;
    logic                          sign_reg,    sign_next;
    logic [PW-1:0]                 opnd_reg,    opnd_next;
    logic [CFW-1:0]                cacc_reg,    cacc_next;
    logic [DW-1:0]                 det_reg,     det_next;
    logic [DW-2:0]                 adet_reg,    adet_next;
    logic                          dneg_reg,    dneg_next;
    logic                          sing_reg,    sing_next;
    logic [mi4_pkg::DET_MIN_W-1:0] dmin_reg,    dmin_next;
    logic                          rv_reg,      rv_next;
    logic [EW-1:0]                 val_reg,     val_next;
    logic [3:0]                    idx_reg,     idx_next;
    logic                          rsing_reg,   rsing_next;
    logic                          rovf_reg,    rovf_next;
    logic                          rlast_reg,   rlast_next;

    logic           e_we;
    logic [3:0]     e_raddr;
    logic [EW-1:0]  e_rdata;
    logic           e_neg;
    logic [EW-1:0]  e_mag;
    logic           c_we;
    logic [3:0]     c_raddr;
    logic [CFW-1:0] c_rdata;
    logic           c_neg;
    logic [CFW-1:0] c_abs;
    logic [MW-1:0]  c_mag;
    logic           mul_start;
    logic [PW-1:0]  mul_a;
    logic [EW-1:0]  mul_b;
    logic           mul_done;
    logic [PW-1:0]  mul_prod;
    logic           div_start;
    logic [NW-1:0]  num_ext;
    logic [NW-1:0]  div_num;
    logic           div_done;
    logic           div_big;
    logic [EW-1:0]  div_quo;
    logic [DW-1:0]  det_abs;
    logic [THRW-1:0] thr;
    logic [EW-1:0]  lim;

    // element store and cofactor store
    mi4_ram #(.WIDTH(EW), .DEPTH(16)) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (load_reg),
        .wdata (element_value),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    mi4_ram #(.WIDTH(CFW), .DEPTH(16)) u_cof_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (j_reg),
        .wdata (cacc_reg),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // shared multiplier and divider
    mi4_mul #(.ELEM_WIDTH(EW), .PW(PW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    mi4_div #(.ELEM_WIDTH(EW), .NW(NW), .DNW(DW - 1)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (adet_reg),
        .done  (div_done),
        .big   (div_big),
        .quo   (div_quo)
    );

    // sign and magnitude of the read operands
    assign e_neg   = e_rdata[EW-1];
    assign e_mag   = e_neg ? (~e_rdata + EW'(1)) : e_rdata;
    assign c_neg   = c_rdata[CFW-1];
    assign c_abs   = c_neg ? (~c_rdata + CFW'(1)) : c_rdata;
    assign c_mag   = c_abs[MW-1:0];
    assign num_ext = NW'(c_mag);
    assign div_num = num_ext << (2 * F);
    assign det_abs = det_reg[DW-1] ? (~det_reg + DW'(1)) : det_reg;
    assign thr     = THRW'(dmin_reg) << (4 * F - 32);
    assign lim     = sign_reg ? (EW'(1) << (EW - 1)) : ((EW'(1) << (EW - 1)) - EW'(1));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        load_next  = load_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        sign_next  = sign_reg;
        opnd_next  = opnd_reg;
        cacc_next  = cacc_reg;
        det_next   = det_reg;
        adet_next  = adet_reg;
        dneg_next  = dneg_reg;
        sing_next  = sing_reg;
        dmin_next  = dmin_reg;
        rv_next    = 1'b0;
        val_next   = val_reg;
        idx_next   = idx_reg;
        rsing_next = rsing_reg;
        rovf_next  = rovf_reg;
        rlast_next = rlast_reg;
        e_we       = 1'b0;
        e_raddr    = '0;
        c_we       = 1'b0;
        c_raddr    = '0;
        mul_start  = 1'b0;
        mul_a      = opnd_reg;
        mul_b      = e_mag;
        div_start  = 1'b0;

        if (cfg_valid)
        begin
            dmin_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                // load one element per transaction
                if (start)
                begin
                    e_we      = 1'b1;
                    load_next = load_reg + 4'd1;
                    if (load_reg == 4'd15)
                    begin
                        j_next     = '0;
                        i_next     = '0;
                        k_next     = '0;
                        cacc_next  = '0;
                        state_next = S_RA;
                    end
                end
            end
            S_RA:
            begin
                e_raddr    = mi4_pkg::COF_TAB[j_reg][i_reg][k_reg];
                state_next = S_RB;
            end
            S_RB:
            begin
                if (k_reg == 2'd0)
                begin
                    opnd_next  = PW'(e_mag);
                    sign_next  = (i_reg >= 3'd3) ^ e_neg;
                    k_next     = 2'd1;
                    state_next = S_RA;
                end
                else
                begin
                    mul_start  = 1'b1;
                    sign_next  = sign_reg ^ e_neg;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    opnd_next = mul_prod;
                    if (k_reg == 2'd2)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_RA;
                    end
                end
            end
            S_ACC:
            begin
                // add or subtract the three-element product
                cacc_next = sign_reg ? (cacc_reg - opnd_reg[CFW-1:0])
                                     : (cacc_reg + opnd_reg[CFW-1:0]);
                i_next    = i_reg + 3'd1;
                k_next    = '0;
                state_next = (i_reg == 3'd5) ? S_CWR : S_RA;
            end
            S_CWR:
            begin
                c_we      = 1'b1;
                j_next    = j_reg + 4'd1;
                i_next    = '0;
                k_next    = '0;
                cacc_next = '0;
                if (j_reg == 4'd15)
                begin
                    r_next     = '0;
                    det_next   = '0;
                    state_next = S_DA;
                end
                else
                begin
                    state_next = S_RA;
                end
            end
            S_DA:
            begin
                // row zero element times its cofactor
                e_raddr    = {2'b00, r_reg};
                c_raddr    = {r_reg, 2'b00};
                state_next = S_DB;
            end
            S_DB:
            begin
                mul_start  = 1'b1;
                mul_a      = PW'(c_mag);
                sign_next  = c_neg ^ e_neg;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                if (mul_done)
                begin
                    det_next = sign_reg ? (det_reg - DW'(mul_prod))
                                        : (det_reg + DW'(mul_prod));
                    r_next   = r_reg + 2'd1;
                    state_next = (r_reg == 2'd3) ? S_CHK : S_DA;
                end
            end
            S_CHK:
            begin
                // singular when zero or below the threshold
                adet_next  = det_abs[DW-2:0];
                dneg_next  = det_reg[DW-1];
                sing_next  = (det_abs == '0) || (CMPW'(det_abs) < CMPW'(thr));
                j_next     = '0;
                state_next = S_ORA;
            end
            S_ORA:
            begin
                c_raddr    = j_reg;
                state_next = S_ORB;
            end
            S_ORB:
            begin
                if (sing_reg)
                begin
                    // identity entry
                    rv_next    = 1'b1;
                    val_next   = (j_reg == 4'd0 || j_reg == 4'd5 || j_reg == 4'd10 ||
                                  j_reg == 4'd15) ? (EW'(1) << F) : '0;
                    idx_next   = j_reg;
                    rsing_next = 1'b1;
                    rovf_next  = 1'b0;
                    rlast_next = (j_reg == 4'd15);
                    j_next     = j_reg + 4'd1;
                    state_next = (j_reg == 4'd15) ? S_IDLE : S_ORA;
                end
                else
                begin
                    div_start  = 1'b1;
                    sign_next  = c_neg ^ dneg_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // saturate and apply the sign
                    rv_next    = 1'b1;
                    idx_next   = j_reg;
                    rsing_next = 1'b0;
                    rlast_next = (j_reg == 4'd15);
                    if (div_big || div_quo > lim)
                    begin
                        rovf_next = 1'b1;
                        val_next  = sign_reg ? (~lim + EW'(1)) : lim;
                    end
                    else
                    begin
                        rovf_next = 1'b0;
                        val_next  = sign_reg ? (~div_quo + EW'(1)) : div_quo;
                    end
                    j_next     = j_reg + 4'd1;
                    state_next = (j_reg == 4'd15) ? S_IDLE : S_ORA;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            load_reg  <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            dmin_reg  <= mi4_pkg::DET_MIN_W'(1);
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            dmin_reg  <= dmin_next;
            rv_reg    <= rv_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        opnd_reg  <= opnd_next;
        cacc_reg  <= cacc_next;
        det_reg   <= det_next;
        adet_reg  <= adet_next;
        dneg_reg  <= dneg_next;
        sing_reg  <= sing_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        rsing_reg <= rsing_next;
        rovf_reg  <= rovf_next;
        rlast_reg <= rlast_next;
    end

    assign result_valid = rv_reg;
    assign inv_value    = val_reg;
    assign elem_index   = idx_reg;
    assign singular     = rsing_reg;
    assign overflow     = rovf_reg;
    assign last         = rlast_reg;

    // results only come out of a run
    a_res_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a run");

    // identity results never carry saturation
    a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && singular) |-> !overflow)
        else $error("singular result flagged as overflow");

    // last transaction of a run is entry fifteen and ends the run
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (elem_index == 4'd15 && !busy))
        else $error("last flag on wrong entry");

endmodule

// File: verif/tb.sv
// self-checking testbench for the 4x4 fixed-point matrix inverse
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = mi4_pkg::ELEM_WIDTH_DEF;
    localparam int FB = mi4_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 1500;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [EW-1:0] value;
        logic [3:0]    index;
        logic          sing;
        logic          ovf;
        logic          last;
    } inv_entry_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [EW-1:0]                 element_value = '0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mi4_pkg::DET_MIN_W-1:0] cfg_data = '0;
    logic                          result_valid;
    logic [EW-1:0]                 inv_value;
    logic [3:0]                    elem_index;
    logic                          singular;
    logic                          overflow;
    logic                          last;

    // predictor state
    logic signed [EW-1:0]          elem_store [16];
    int unsigned                   load_pos = 0;
    logic [mi4_pkg::DET_MIN_W-1:0] det_min_q = mi4_pkg::DET_MIN_W'(1);
    inv_entry_t                    pending_inv [$];

    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    matrix_inverse_4x4 uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .element_value(element_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .inv_value(inv_value),
        .elem_index(elem_index), .singular(singular),
        .overflow(overflow), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // cofactor sum of inverse entry j, 3*FB fraction bits
    function automatic wide_t cofactor_sum(int j);
        wide_t acc;
        wide_t t;
        acc = '0;
        for (int i = 0; i < 6; i++)
        begin
            t = wide_t'(elem_store[mi4_pkg::COF_TAB[j][i][0]]) *
                wide_t'(elem_store[mi4_pkg::COF_TAB[j][i][1]]) *
                wide_t'(elem_store[mi4_pkg::COF_TAB[j][i][2]]);
            acc = (i < 3) ? acc + t : acc - t;
        end
        return acc;
    endfunction

    // queue the sixteen inverse entries of the stored matrix
    task automatic predict_inverse();
        wide_t cof [16];
        wide_t det, adet, thr, num, q, lim;
        bit    sing, neg;
        inv_entry_t e;
        det = '0;
        for (int j = 0; j < 16; j++)
            cof[j] = cofactor_sum(j);
        for (int j = 0; j < 4; j++)
            det = det + wide_t'(elem_store[j]) * cof[4*j];
        adet = (det < 0) ? -det : det;
        thr = wide_t'({1'b0, det_min_q}) <<< (4*FB - 32);
        sing = (adet == 0) || (adet < thr);
        for (int j = 0; j < 16; j++)
        begin
            e.index = j[3:0];
            e.sing  = sing;
            e.last  = (j == 15);
            e.ovf   = 1'b0;
            if (sing)
                e.value = (j % 5 == 0) ? EW'(1) << FB : '0;
            else
            begin
                num = cof[j] <<< (2*FB);
                neg = (num < 0) != (det < 0);
                q = ((num < 0) ? -num : num) / adet;
                lim = (wide_t'(1) <<< (EW-1)) - (neg ? 0 : 1);
                if (q > lim)
                begin
                    q = lim;
                    e.ovf = 1'b1;
                end
                if (neg)
                    q = -q;
                e.value = q[EW-1:0];
            end
            pending_inv.push_back(e);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        inv_entry_t e;
        if (rst_n && result_valid)
        begin
            if (pending_inv.size() == 0)
            begin
                $display("%0t unexpected result index %0d value %h", $time,
                         elem_index, inv_value);
                errors++;
            end
            else
            begin
                e = pending_inv.pop_front();
                if (inv_value !== e.value || elem_index !== e.index ||
                    singular !== e.sing || overflow !== e.ovf || last !== e.last)
                begin
                    $display("%0t mismatch exp val %h idx %0d sing %b ovf %b last %b",
                             $time, e.value, e.index, e.sing, e.ovf, e.last);
                    $display("%0t          act val %h idx %0d sing %b ovf %b last %b",
                             $time, inv_value, elem_index, singular, overflow, last);
                    errors++;
                end
            end
        end
    end

    // one element transaction; start is left high for a back-to-back item
    task automatic send_element(logic [EW-1:0] v);
        while (!calm && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        element_value = v;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        elem_store[load_pos] = v;
        load_pos = (load_pos + 1) % 16;
        if (load_pos == 0)
            predict_inverse();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_inv.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // threshold write, only while idle
    task automatic set_det_min(logic [mi4_pkg::DET_MIN_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        det_min_q = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [EW-1:0] rand_elem(int mode);
        case (mode)
            0: return $urandom();
            1: return EW'($signed($urandom_range(8 << FB)) - (4 << FB));
            2: return ($urandom_range(3) == 0) ? EW'($urandom()) : '0;
            default: return EW'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic send_matrix(int mode);
        for (int k = 0; k < 16; k++)
            send_element(rand_elem(mode));
    endtask

    task automatic test_identity();
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? EW'(1) << FB : '0);
        // scaled identity: all extremes on the diagonal
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? {1'b1, {(EW-1){1'b0}}} : '0);
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? {1'b0, {(EW-1){1'b1}}} : '0);
    endtask

    task automatic test_zero_det();
        set_det_min('0);
        // zero determinant is singular even with a zero threshold
        for (int k = 0; k < 16; k++)
            send_element('0);
        // tiny diagonal: nonsingular at zero threshold, saturates
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? EW'(1) : '0);
        for (int k = 0; k < 16; k++)
            send_element((k == 0) ? '1 : ((k % 5 == 0) ? EW'(1) : '0));
    endtask

    task automatic test_random(int matrices);
        for (int m = 0; m < matrices; m++)
        begin
            calm = (m >= matrices / 2 && m < matrices / 2 + 3);
            send_matrix($urandom_range(3));
        end
        calm = 1'b0;
    endtask

    task automatic test_thresholds();
        set_det_min(mi4_pkg::DET_MIN_W'(64'd1 << 32));
        test_random(4);
        set_det_min({mi4_pkg::DET_MIN_W{1'b1}});
        test_random(2);
        set_det_min(mi4_pkg::DET_MIN_W'($urandom_range(1000)));
        test_random(2);
        set_det_min(mi4_pkg::DET_MIN_W'(1));
        test_random(4);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_identity();
        test_zero_det();
        set_det_min(mi4_pkg::DET_MIN_W'(1));
        test_random(4);
        test_thresholds();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_inv.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
